/* src/b64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg: shared types, constants and character maps
// Holds the job record that travels from the front end to the output
// sequencer, and the base64 alphabet mapping in both directions.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  localparam logic       DIR_ENCODE = 1'b0;
  localparam logic       DIR_DECODE = 1'b1;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;

  // One input item's worth of results: bytes in output order, index of the
  // final one, and whether the item closed its message.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            msg_end;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = {2'b00, v} + 8'd65;
    end else if (v < 6'd52) begin
      r = {2'b00, v} + 8'd71;
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Anything outside the alphabet, the pad character included, maps to zero.
  function automatic logic [5:0] dec_char(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c + 8'd4;
    end else if (c == 8'h2B) begin
      r = 8'd62;
    end else if (c == 8'h2F) begin
      r = 8'd63;
    end else begin
      r = 8'd0;
    end
    return r[5:0];
  endfunction

endpackage

/* src/base64_stream_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// Standard alphabet; the direction register picks encode or decode.
// ----------------------------------------------------------------------------
// An input item is taken in the cycle it arrives whenever the two-entry job
// queue has room, and its results leave one per cycle, unless the output
// stalls, from a registered output; each item's job passes through the
// queue entry and the sequencer's job register before its first result is
// registered at the output. Further items are taken while earlier results
// are still leaving, as long as the queue has room. Write the direction
// only while no results are pending; a write clears the group state.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       msg_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       out_msg_end
);
  import b64_pkg::*;

  logic push;
  job_t push_data;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .msg_end   (msg_end),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  b64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  b64_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .out_msg_end (out_msg_end)
  );

endmodule

/* src/b64_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front: item intake and group tracking
// Holds the direction register and the group state, takes one item per
// cycle while the queue has room, and builds jobs of up to four result bytes.
// ----------------------------------------------------------------------------
module b64_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic          cfg_data,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          msg_end,
  input  logic          q_full,
  output logic          push,
  output b64_pkg::job_t push_data
);
  import b64_pkg::*;

  logic        direction;
  logic [1:0]  group_pos;
  logic [23:0] held_bits;
  logic        third_is_pad;

  logic [1:0]  group_pos_next;
  logic [23:0] held_bits_next;
  logic        third_is_pad_next;
  logic        has_result;
  logic        accept;
  logic [5:0]  dval;
  logic [23:0] shifted;

  assign accept  = in_valid && !q_full;
  assign dval    = dec_char(in_byte);
  assign shifted = {held_bits[17:0], dval};

  always_comb begin
    group_pos_next    = group_pos;
    held_bits_next    = held_bits;
    third_is_pad_next = third_is_pad;
    has_result        = 1'b0;
    push_data.bytes   = '0;
    push_data.last_idx = 2'd0;
    push_data.msg_end = msg_end;
    if (direction == DIR_ENCODE) begin
      has_result     = 1'b1;
      held_bits_next = {16'd0, in_byte};
      case (group_pos)
        2'd0: begin
          push_data.bytes[0] = enc_char(in_byte[7:2]);
          if (msg_end) begin
            push_data.bytes[1] = enc_char({in_byte[1:0], 4'd0});
            push_data.bytes[2] = PAD_CHAR;
            push_data.bytes[3] = PAD_CHAR;
            push_data.last_idx = 2'd3;
          end
          group_pos_next = 2'd1;
        end
        2'd1: begin
          push_data.bytes[0] = enc_char({held_bits[1:0], in_byte[7:4]});
          if (msg_end) begin
            push_data.bytes[1] = enc_char({in_byte[3:0], 2'd0});
            push_data.bytes[2] = PAD_CHAR;
            push_data.last_idx = 2'd2;
          end
          group_pos_next = 2'd2;
        end
        default: begin
          push_data.bytes[0] = enc_char({held_bits[3:0], in_byte[7:6]});
          push_data.bytes[1] = enc_char(in_byte[5:0]);
          push_data.last_idx = 2'd1;
          group_pos_next     = 2'd0;
        end
      endcase
    end else begin
      if (group_pos == 2'd3) begin
        has_result         = 1'b1;
        push_data.bytes[0] = shifted[23:16];
        push_data.bytes[1] = shifted[15:8];
        push_data.bytes[2] = shifted[7:0];
        if (in_byte == PAD_CHAR) begin
          push_data.last_idx = third_is_pad ? 2'd0 : 2'd1;
        end else begin
          push_data.last_idx = 2'd2;
        end
        group_pos_next    = 2'd0;
        held_bits_next    = '0;
        third_is_pad_next = 1'b0;
      end else begin
        if (group_pos == 2'd2) begin
          third_is_pad_next = (in_byte == PAD_CHAR);
        end
        held_bits_next = shifted;
        group_pos_next = group_pos + 2'd1;
      end
    end
    if (msg_end) begin
      group_pos_next    = 2'd0;
      held_bits_next    = '0;
      third_is_pad_next = 1'b0;
    end
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_ENCODE;
      group_pos    <= 2'd0;
      held_bits    <= '0;
      third_is_pad <= 1'b0;
    end else if (cfg_valid) begin
      direction    <= cfg_data;
      group_pos    <= 2'd0;
      held_bits    <= '0;
      third_is_pad <= 1'b0;
    end else if (accept) begin
      group_pos    <= group_pos_next;
      held_bits    <= held_bits_next;
      third_is_pad <= third_is_pad_next;
    end
  end

endmodule

/* src/b64_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_queue: job queue between front end and output sequencer
// A small register FIFO that lets intake and output stall independently.
// ----------------------------------------------------------------------------
module b64_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output b64_pkg::job_t head
);
  import b64_pkg::*;

  job_t                entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full      = (count == QCOUNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCOUNT_W'(QDEPTH))
    else $error("job queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("job popped from an empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> count == $past(count) + 1'b1)
    else $error("job queue count did not follow a push");
`endif

endmodule

/* src/b64_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back: output sequencer
// Takes one job at a time from the queue and sends its bytes out one per
// transfer through a registered output stage.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  b64_pkg::job_t q_head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          out_msg_end
);
  import b64_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       advance;
  logic       finishing;

  assign advance   = busy && (!out_valid || !out_stall);
  assign finishing = advance && (idx == cur.last_idx);
  assign pop       = q_valid && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= cur.bytes[idx];
      run_last    <= (idx == cur.last_idx);
      out_msg_end <= (idx == cur.last_idx) && cur.msg_end;
    end
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (!finishing) begin
          idx <= idx + 2'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // A new job can be picked up in the same cycle the current one ends.
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
